>>> hw/rtl/salru_pkg.sv
// shared constants for the set-associative lru tag store
// no dependencies
`default_nettype none

package salru_pkg;

	// payload widths
	localparam int unsigned ADDR_W = 31;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned WAY_OUT_W = 2;

	// configuration port
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned NSETS_W = 7;
	localparam int unsigned NWAYS_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_SETS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_WAYS = 1'd1;

	localparam logic [NSETS_W-1:0] NUM_SETS_RST = 7'd64;
	localparam logic [NWAYS_W-1:0] NUM_WAYS_RST = 3'd4;

	// default geometry
	localparam int unsigned SETS_DEF = 64;
	localparam int unsigned WAYS_DEF = 4;

endpackage

`default_nettype wire

>>> hw/rtl/salru_if.sv
// handshake channels for lookup words and result words
// depends on salru_pkg
`default_nettype none

interface salru_in_if;
	logic                          valid;
	logic                          ready;
	logic [salru_pkg::ADDR_W-1:0]  address;
	logic [salru_pkg::TIME_W-1:0]  access_time;

	modport source (output valid, output address, output access_time, input ready);
	modport sink (input valid, input address, input access_time, output ready);
endinterface

interface salru_out_if;
	logic                             valid;
	logic                             ready;
	logic                             hit;
	logic [salru_pkg::WAY_OUT_W-1:0]  way;

	modport source (output valid, output hit, output way, input ready);
	modport sink (input valid, input hit, input way, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/salru_front.sv
// front end: accepts a lookup word and finds its set with a bit-serial remainder
// depends on salru_pkg, salru_in_if
`default_nettype none

module salru_front #(
	parameter int unsigned SW = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [salru_pkg::NSETS_W-1:0] ns,
	salru_in_if.sink                           in,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output logic [salru_pkg::ADDR_W-1:0]       push_addr,
	output logic [salru_pkg::TIME_W-1:0]       push_tim,
	output logic [SW-1:0]                      push_set
);

	localparam int unsigned CNT_W = $clog2(salru_pkg::ADDR_W);
	localparam int unsigned RW = salru_pkg::NSETS_W;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_t;

	state_t                        state_q;
	logic [salru_pkg::ADDR_W-1:0]  addr_q;
	logic [salru_pkg::TIME_W-1:0]  tim_q;
	logic [RW-1:0]                 rem_q;
	logic [RW-1:0]                 div_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [RW:0]                   trial;
	logic [RW:0]                   diff;
	logic [RW-1:0]                 rem_nxt;
	logic [SW+RW-1:0]              rem_ext;

	// one restoring step per cycle, msb first
	always_comb begin
		trial = {rem_q, addr_q[cnt_q]};
		diff = trial - {1'b0, div_q};
		rem_nxt = (trial >= {1'b0, div_q}) ? diff[RW-1:0] : trial[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rem_q <= '0;
			div_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in.valid) begin
						state_q <= ST_DIV;
						cnt_q <= CNT_W'(salru_pkg::ADDR_W - 1);
						rem_q <= '0;
						div_q <= ns;
					end
				end
				ST_DIV: begin
					rem_q <= rem_nxt;
					if (cnt_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in.valid) begin
			addr_q <= in.address;
			tim_q <= in.access_time;
		end
	end

	assign in.ready = (state_q == ST_IDLE);
	assign push_valid = (state_q == ST_PUSH);
	assign push_addr = addr_q;
	assign push_tim = tim_q;
	assign rem_ext = {{SW{1'b0}}, rem_q};
	assign push_set = rem_ext[SW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/salru_fifo.sv
// two-word queue between front end and back end
// no dependencies beyond its parameter
`default_nettype none

module salru_fifo #(
	parameter int unsigned DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire logic [DW-1:0] wr_data,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output logic [DW-1:0]      rd_data
);

	logic [DW-1:0] mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

endmodule

`default_nettype wire

>>> hw/rtl/salru_back.sv
// back end: row memory, way walk for hit and lru victim, write-back and result register
// depends on salru_pkg, salru_out_if
`default_nettype none

module salru_back #(
	parameter int unsigned SETS = salru_pkg::SETS_DEF,
	parameter int unsigned WAYS = salru_pkg::WAYS_DEF,
	parameter int unsigned SW = 6,
	parameter int unsigned WI = 2,
	parameter int unsigned WCW = 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [WCW-1:0]               nw,
	input  wire logic                         q_valid,
	output logic                              q_ready,
	input  wire logic [salru_pkg::ADDR_W-1:0] q_addr,
	input  wire logic [salru_pkg::TIME_W-1:0] q_tim,
	input  wire logic [SW-1:0]                q_set,
	salru_out_if.source                       out
);

	localparam int unsigned AW = salru_pkg::ADDR_W;
	localparam int unsigned TW = salru_pkg::TIME_W;

	typedef struct packed {
		logic [WAYS-1:0]         vld;
		logic [WAYS-1:0][AW-1:0] tag;
		logic [WAYS-1:0][TW-1:0] tim;
	} row_t;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_WB} state_t;

	row_t          mem [SETS];
	row_t          row_q;
	row_t          row_new;
	state_t        state_q;
	logic [SW-1:0] clr_q;
	logic [SW-1:0] set_q;
	logic [AW-1:0] addr_q;
	logic [TW-1:0] tim_q;
	logic [WI-1:0] w_q;
	logic          inv_q;
	logic [WI-1:0] inv_idx_q;
	logic [TW-1:0] best_q;
	logic [WI-1:0] best_idx_q;
	logic [WI-1:0] vic_q;
	logic          hit_q;
	logic          out_valid_q;
	logic          out_hit_q;
	logic [WI-1:0] out_way_q;
	logic          pop;

	// walk of one way
	logic          cur_v;
	logic          cur_hit;
	logic          last;
	logic          inv_nxt;
	logic [WI-1:0] inv_idx_nxt;
	logic [TW-1:0] best_nxt;
	logic [WI-1:0] best_idx_nxt;
	logic [WI+1:0] way_ext;

	assign pop = (state_q == ST_IDLE) && q_valid && !out_valid_q;
	assign q_ready = pop;

	always_comb begin
		cur_v = row_q.vld[w_q];
		cur_hit = cur_v && (row_q.tag[w_q] == addr_q);
		last = ((WCW+1)'(w_q) + (WCW+1)'(1)) == {1'b0, nw};
		inv_nxt = inv_q;
		inv_idx_nxt = inv_idx_q;
		if (!cur_v && !inv_q) begin
			inv_nxt = 1'b1;
			inv_idx_nxt = w_q;
		end
		best_nxt = best_q;
		best_idx_nxt = best_idx_q;
		if (w_q == '0 || row_q.tim[w_q] < best_q) begin
			best_nxt = row_q.tim[w_q];
			best_idx_nxt = w_q;
		end
	end

	// updated row for the write-back
	always_comb begin
		row_new = row_q;
		row_new.vld[vic_q] = 1'b1;
		row_new.tag[vic_q] = addr_q;
		row_new.tim[vic_q] = tim_q;
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			w_q <= '0;
			inv_q <= 1'b0;
		end else begin
			if (out_valid_q && out.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == SW'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + SW'(1);
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_WALK;
						w_q <= '0;
						inv_q <= 1'b0;
					end
				end
				ST_WALK: begin
					inv_q <= inv_nxt;
					inv_idx_q <= inv_idx_nxt;
					best_q <= best_nxt;
					best_idx_q <= best_idx_nxt;
					if (cur_hit) begin
						hit_q <= 1'b1;
						vic_q <= w_q;
						state_q <= ST_WB;
					end else if (last) begin
						hit_q <= 1'b0;
						vic_q <= inv_nxt ? inv_idx_nxt : best_idx_nxt;
						state_q <= ST_WB;
					end else begin
						w_q <= w_q + WI'(1);
					end
				end
				ST_WB: begin
					out_valid_q <= 1'b1;
					out_hit_q <= hit_q;
					out_way_q <= vic_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// word capture on pop
	always_ff @(posedge clk) begin
		if (pop) begin
			set_q <= q_set;
			addr_q <= q_addr;
			tim_q <= q_tim;
		end
	end

	// row memory, one row per set, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (state_q == ST_WB) begin
			mem[set_q] <= row_new;
		end
		if (pop) row_q <= mem[q_set];
	end

	assign way_ext = {2'b00, out_way_q};
	assign out.valid = out_valid_q;
	assign out.hit = out_hit_q;
	assign out.way = way_ext[salru_pkg::WAY_OUT_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/set_assoc_cache_lru_lookup.sv
// the front end accepts a word, finds one remainder bit per cycle over the 31 address
// bits and hands it off; the back end reads the row, walks one way per cycle, then writes
// the row back and registers the result word
// the front end takes no new word until it has handed the last one to the queue
// reset: configuration returns to 64 sets, 4 ways; the back end then clears one row per
// cycle, every row, before it takes the first word, the front end still accepts
`default_nettype none

module set_assoc_cache_lru_lookup #(
	parameter int unsigned SETS = salru_pkg::SETS_DEF,
	parameter int unsigned WAYS = salru_pkg::WAYS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [salru_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [salru_pkg::CFG_DATA_W-1:0] cfg_data,
	salru_in_if.sink                              in,
	salru_out_if.source                           out
);

	localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned WI = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned WCW = $clog2(WAYS + 1);
	localparam int unsigned QW = salru_pkg::ADDR_W + salru_pkg::TIME_W + SW;

	logic [salru_pkg::NSETS_W-1:0] num_sets_q;
	logic [salru_pkg::NWAYS_W-1:0] num_ways_q;
	logic [10:0]                   ns_wide;
	logic [salru_pkg::NSETS_W-1:0] ns;
	logic [4:0]                    nw_wide;
	logic [WCW-1:0]                nw;

	logic                          f_valid;
	logic                          f_ready;
	logic [salru_pkg::ADDR_W-1:0]  f_addr;
	logic [salru_pkg::TIME_W-1:0]  f_tim;
	logic [SW-1:0]                 f_set;
	logic                          b_valid;
	logic                          b_ready;
	logic [QW-1:0]                 b_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sets_q <= salru_pkg::NUM_SETS_RST;
			num_ways_q <= salru_pkg::NUM_WAYS_RST;
		end else if (cfg_we) begin
			if (cfg_idx == salru_pkg::REG_NUM_SETS) num_sets_q <= cfg_data;
			if (cfg_idx == salru_pkg::REG_NUM_WAYS) num_ways_q <= cfg_data[salru_pkg::NWAYS_W-1:0];
		end
	end

	// effective set and way counts
	always_comb begin
		ns_wide = 11'(num_sets_q);
		if (num_sets_q == '0) ns_wide = 11'd1;
		else if (ns_wide > 11'(SETS)) ns_wide = 11'(SETS);
		ns = ns_wide[salru_pkg::NSETS_W-1:0];
		nw_wide = 5'(num_ways_q);
		if (num_ways_q == '0) nw_wide = 5'd1;
		else if (nw_wide > 5'(WAYS)) nw_wide = 5'(WAYS);
		nw = nw_wide[WCW-1:0];
	end

	salru_front #(.SW(SW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ns         (ns),
		.in         (in),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_addr  (f_addr),
		.push_tim   (f_tim),
		.push_set   (f_set)
	);

	salru_fifo #(.DW(QW)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_addr, f_tim, f_set}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	salru_back #(
		.SETS (SETS),
		.WAYS (WAYS),
		.SW   (SW),
		.WI   (WI),
		.WCW  (WCW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.nw      (nw),
		.q_valid (b_valid),
		.q_ready (b_ready),
		.q_addr  (b_data[QW-1 -: salru_pkg::ADDR_W]),
		.q_tim   (b_data[SW +: salru_pkg::TIME_W]),
		.q_set   (b_data[SW-1:0]),
		.out     (out)
	);

endmodule

`default_nettype wire

>>> hw/rtl/salru_chk.sv
// port-level checks for the lru tag store, bound to the top level
// depends on salru_pkg
`default_nettype none

module salru_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic                             out_hit,
	input wire logic [salru_pkg::WAY_OUT_W-1:0]  out_way
);

	logic [3:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
	end

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_way))
		else $error("result word changed while stalled");

	// no result without an outstanding lookup
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("result word without a lookup");

	// front, queue, back and result register bound the words in flight
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd4)
		else $error("too many words in flight");

endmodule

bind set_assoc_cache_lru_lookup salru_chk u_salru_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in.valid),
	.in_ready  (in.ready),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_hit   (out.hit),
	.out_way   (out.way)
);

`default_nettype wire
